[hw/rtl/qbs_pkg.sv]
// ----------------------------------------------------------------------------
// Queued beep sequencer package
// Shared types and constants: request entry layout, phase codes, command
// codes and configuration register indexes.
// ----------------------------------------------------------------------------
package qbs_pkg;

  // Default number of queued requests.
  localparam int QUEUE_DEPTH_DEF = 8;

  // Field widths of one request, the scale register, the fill report and the configuration port.
  localparam int FREQ_W  = 16;
  localparam int MS_W    = 16;
  localparam int SCALE_W = 16;
  localparam int QUEUED_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Reset value of the period scale register.
  localparam logic [SCALE_W-1:0] PERIOD_SCALE_RST = 16'd1;

  // Command codes of an input item.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ENQUEUE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SCALE = 1'b1;

  // One stored beep request.
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   tone;
    logic [MS_W-1:0]   silence;
  } beep_entry_t;

  // Playback phase.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_TONE = 3'b010,
    PH_MUTE = 3'b100
  } phase_t;

endpackage

[hw/rtl/qbs_store.sv]
// ----------------------------------------------------------------------------
// Beep request store
// Ring storage for queued requests with one write port and one registered
// read port. A write to the address being read is passed to the read data.
// ----------------------------------------------------------------------------
module qbs_store #(
  parameter int DEPTH = qbs_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  qbs_pkg::beep_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output qbs_pkg::beep_entry_t rdata
);
  import qbs_pkg::*;

  beep_entry_t mem_r [DEPTH];
  beep_entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, new data first on an address collision.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/queued_beep_sequencer.sv]
// ----------------------------------------------------------------------------
// Queued beep sequencer
// Plays queued beep requests in order, each as a tone phase followed by an
// optional mute phase, and reports the PWM settings after every item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per handshake: a millisecond tick
//   (cmd 0) or a beep request to enqueue (cmd 1, with frequency, tone and
//   mute durations). Every input item yields exactly one result item on the
//   output channel with the tone enable, PWM period and compare, busy flag,
//   drop flag and queue fill after that item.
//   An item is taken into an input register, processed in one pass and
//   written to the output register; one item per cycle is sustained while
//   the receiver does not stall. The request
//   queue is read through a registered port that always holds the entry
//   after the one playing, so a phase change never waits on the memory.
//   When the receiver stalls, the output register holds its result and the
//   input register fills; after that the input channel stalls too.
//   Reset clears the queue pointers, the fill count and the phase, disables
//   enqueue and sets the period scale to one; the store needs no clearing.
//   Configuration is written through cfg_we, cfg_index and cfg_wdata.
// ----------------------------------------------------------------------------
module queued_beep_sequencer #(
  parameter int QUEUE_DEPTH = qbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration port
  input  logic                               cfg_we,
  input  logic [qbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [qbs_pkg::FREQ_W-1:0]         in_tone_freq,
  input  logic [qbs_pkg::MS_W-1:0]           in_tone_ms,
  input  logic [qbs_pkg::MS_W-1:0]           in_silence_ms,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_tone_on,
  output logic [qbs_pkg::FREQ_W-1:0]         out_pwm_period,
  output logic [qbs_pkg::FREQ_W-2:0]         out_pwm_compare,
  output logic                               out_busy_res,
  output logic                               out_dropped,
  output logic [qbs_pkg::QUEUED_W-1:0]       out_queued
);
  import qbs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ZERO  = '0;
  localparam logic [MS_W-1:0]  MS_ONE    = MS_W'(1);

  // Ring pointer increment with wrap at the queue depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Configuration registers.
  logic               enabled_r;
  logic [SCALE_W-1:0] period_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r      <= 1'b0;
      period_scale_r <= PERIOD_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:      enabled_r      <= cfg_wdata[0];
        REG_PERIOD_SCALE: period_scale_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic              in_v_r;
  logic              cmd_r;
  beep_entry_t       req_r;
  logic              go;
  logic              out_v_r;

  assign go       = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r       <= in_cmd;
      req_r.freq    <= in_tone_freq;
      req_r.tone    <= in_tone_ms;
      req_r.silence <= in_silence_ms;
    end
  end

  // Sequencer state.
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  phase_t           phase_r, phase_nxt;
  logic [MS_W-1:0]  ms_r, ms_nxt;
  logic [FREQ_W-1:0] cur_freq_r, cur_freq_nxt;
  logic [MS_W-1:0]  cur_sil_r, cur_sil_nxt;
  logic             dropped_nxt;
  logic             store_we;
  beep_entry_t      next_entry;
  logic [CNT_W-1:0] cnt_dec;

  assign cnt_dec = cnt_r - CNT_ONE;

  // Next state for one item.
  always_comb begin
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    cnt_nxt      = cnt_r;
    phase_nxt    = phase_r;
    ms_nxt       = ms_r;
    cur_freq_nxt = cur_freq_r;
    cur_sil_nxt  = cur_sil_r;
    dropped_nxt  = 1'b0;
    store_we     = 1'b0;
    if (go) begin
      if (cmd_r == CMD_ENQUEUE) begin
        if (!enabled_r || (cnt_r == CNT_FULL)) begin
          dropped_nxt = 1'b1;
        end else begin
          store_we = 1'b1;
          wp_nxt   = ptr_inc(wp_r);
          cnt_nxt  = cnt_r + CNT_ONE;
          if (cnt_r == CNT_ZERO) begin
            phase_nxt    = PH_TONE;
            ms_nxt       = req_r.tone;
            cur_freq_nxt = req_r.freq;
            cur_sil_nxt  = req_r.silence;
          end
        end
      end else if (phase_r != PH_IDLE) begin
        if (ms_r > MS_ONE) begin
          ms_nxt = ms_r - MS_ONE;
        end else if ((phase_r == PH_TONE) && (cur_sil_r != '0)) begin
          phase_nxt = PH_MUTE;
          ms_nxt    = cur_sil_r;
        end else begin
          // Current entry is done: start the next one or go idle.
          rp_nxt  = ptr_inc(rp_r);
          cnt_nxt = cnt_dec;
          if (cnt_dec == CNT_ZERO) begin
            phase_nxt = PH_IDLE;
            ms_nxt    = '0;
          end else begin
            phase_nxt    = PH_TONE;
            ms_nxt       = next_entry.tone;
            cur_freq_nxt = next_entry.freq;
            cur_sil_nxt  = next_entry.silence;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      phase_r <= PH_IDLE;
      ms_r    <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      ms_r    <= ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_freq_r <= cur_freq_nxt;
    cur_sil_r  <= cur_sil_nxt;
  end

  // Request store; the read port tracks the entry after the playing one.
  qbs_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp_r),
    .wdata (req_r),
    .raddr (ptr_inc(rp_nxt)),
    .rdata (next_entry)
  );

  // Result values after the item.
  logic                      tone_on_nxt;
  logic [2*FREQ_W-1:0]       product;
  logic [FREQ_W-1:0]         period_nxt;
  logic [CNT_W+QUEUED_W-1:0] cnt_ext;

  assign tone_on_nxt = (phase_nxt == PH_TONE);
  assign product     = cur_freq_nxt * period_scale_r;
  assign period_nxt  = tone_on_nxt ? product[FREQ_W-1:0] : '0;
  assign cnt_ext     = {{QUEUED_W{1'b0}}, cnt_nxt};

  // Output register.
  logic                tone_on_r;
  logic [FREQ_W-1:0]   period_r;
  logic                busy_r;
  logic                dropped_r;
  logic [QUEUED_W-1:0] queued_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      tone_on_r <= tone_on_nxt;
      period_r  <= period_nxt;
      busy_r    <= (cnt_nxt != CNT_ZERO);
      dropped_r <= dropped_nxt;
      queued_r  <= cnt_ext[QUEUED_W-1:0];
    end
  end

  assign out_valid       = out_v_r;
  assign out_tone_on     = tone_on_r;
  assign out_pwm_period  = period_r;
  assign out_pwm_compare = period_r[FREQ_W-1:1];
  assign out_busy_res    = busy_r;
  assign out_dropped     = dropped_r;
  assign out_queued      = queued_r;

  // The fill count never passes the queue depth.
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue fill count above depth");

  // Idle exactly when the queue is empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) == (cnt_r == CNT_ZERO))
    else $error("phase and fill count disagree");

  // A rejected request leaves the queue untouched.
  a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (go && dropped_nxt) |=> ((cnt_r == $past(cnt_r)) && (wp_r == $past(wp_r))))
    else $error("dropped request changed the queue");

  // A tone is only reported while something is queued.
  a_tone_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && tone_on_r) |-> busy_r)
    else $error("tone reported with empty queue");

endmodule

[sim/tb_queued_beep_sequencer.sv]
// ----------------------------------------------------------------------------
// Queued beep sequencer testbench
// Sends tick and enqueue items through the valid/stall input channel while
// the result channel stalls at random. A scoreboard predicts each result from
// its own copy of the queue, the playback phase and the registers, and then
// compares every field of every result in order. The run walks through
// several register settings, including scale zero, scale one, full scale and
// enqueue disabled.
// ----------------------------------------------------------------------------
module tb_queued_beep_sequencer;
  import qbs_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 60;

  // Fields of one result item.
  typedef struct {
    logic                  tone_on;
    logic [FREQ_W-1:0]     period;
    logic [FREQ_W-2:0]     compare;
    logic                  busy;
    logic                  dropped;
    logic [QUEUED_W-1:0]   queued;
  } beep_result_t;

  // Predicts the sequencer's results and checks them in order.
  class beep_scoreboard;
    beep_entry_t        store [DEPTH];
    int                 wr_ptr;
    int                 rd_ptr;
    int                 fill;
    phase_t             play_phase;
    logic [MS_W-1:0]    ms_left;
    logic               enabled;
    logic [SCALE_W-1:0] scale;
    beep_result_t       expected_results [$];
    int                 errors;
    int                 checked;

    function new();
      wr_ptr     = 0;
      rd_ptr     = 0;
      fill       = 0;
      play_phase = PH_IDLE;
      ms_left    = '0;
      enabled    = 1'b0;
      scale      = PERIOD_SCALE_RST;
      errors     = 0;
      checked    = 0;
    endfunction

    // Mirrors one register write.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ENABLED) begin
        enabled = data[0];
      end else if (idx == REG_PERIOD_SCALE) begin
        scale = data[SCALE_W-1:0];
      end
    endfunction

    // Loads the tone phase of the entry at the read pointer.
    function void start_entry();
      play_phase = PH_TONE;
      ms_left    = store[rd_ptr].tone;
    endfunction

    // One millisecond: count down, or move to mute, next entry or idle.
    function void count_down_ms();
      if (play_phase == PH_IDLE) return;
      if (ms_left > 1) begin
        ms_left = ms_left - 1'b1;
        return;
      end
      if (play_phase == PH_TONE && store[rd_ptr].silence != '0) begin
        play_phase = PH_MUTE;
        ms_left    = store[rd_ptr].silence;
        return;
      end
      rd_ptr = (rd_ptr + 1) % DEPTH;
      if (fill > 0) fill--;
      if (fill == 0) begin
        play_phase = PH_IDLE;
        ms_left    = '0;
      end else begin
        start_entry();
      end
    endfunction

    // Applies one accepted input item and queues the result it causes.
    function void note_item(logic cmd, logic [FREQ_W-1:0] f, logic [MS_W-1:0] t,
                            logic [MS_W-1:0] s);
      beep_result_t r;
      logic [31:0]  prod;
      logic         was_empty;
      r.dropped = 1'b0;
      if (cmd == CMD_ENQUEUE) begin
        if (!enabled || fill >= DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          was_empty             = (fill == 0);
          store[wr_ptr].freq    = f;
          store[wr_ptr].tone    = t;
          store[wr_ptr].silence = s;
          wr_ptr                = (wr_ptr + 1) % DEPTH;
          fill++;
          if (was_empty) start_entry();
        end
      end else begin
        count_down_ms();
      end
      r.tone_on = (play_phase == PH_TONE);
      prod      = '0;
      if (r.tone_on) prod = store[rd_ptr].freq * scale;
      r.period  = prod[FREQ_W-1:0];
      r.compare = prod[FREQ_W-1:1];
      r.busy    = (fill != 0);
      r.queued  = fill[QUEUED_W-1:0];
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Prints one line per mismatch and counts it.
    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    // Compares one accepted result with the oldest prediction.
    task check_result(beep_result_t got);
      beep_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d arrived with no item pending", checked));
        return;
      end
      want = expected_results.pop_front();
      if (got.tone_on !== want.tone_on)
        report($sformatf("result %0d tone_on %b, expected %b", checked, got.tone_on,
                         want.tone_on));
      if (got.period !== want.period)
        report($sformatf("result %0d pwm_period %h, expected %h", checked, got.period,
                         want.period));
      if (got.compare !== want.compare)
        report($sformatf("result %0d pwm_compare %h, expected %h", checked, got.compare,
                         want.compare));
      if (got.busy !== want.busy)
        report($sformatf("result %0d busy_res %b, expected %b", checked, got.busy,
                         want.busy));
      if (got.dropped !== want.dropped)
        report($sformatf("result %0d dropped %b, expected %b", checked, got.dropped,
                         want.dropped));
      if (got.queued !== want.queued)
        report($sformatf("result %0d queued %0d, expected %0d", checked, got.queued,
                         want.queued));
      checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cmd = CMD_TICK;
  logic [FREQ_W-1:0]     in_tone_freq = '0;
  logic [MS_W-1:0]       in_tone_ms = '0;
  logic [MS_W-1:0]       in_silence_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_tone_on;
  logic [FREQ_W-1:0]     out_pwm_period;
  logic [FREQ_W-2:0]     out_pwm_compare;
  logic                  out_busy_res;
  logic                  out_dropped;
  logic [QUEUED_W-1:0]   out_queued;

  beep_scoreboard sb = new();
  bit             sender_gaps = 1'b1;
  bit             receiver_gaps = 1'b1;
  bit             hold_request = 1'b0;
  int             cycles = 0;

  queued_beep_sequencer #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_tone_freq    (in_tone_freq),
    .in_tone_ms      (in_tone_ms),
    .in_silence_ms   (in_silence_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tone_on     (out_tone_on),
    .out_pwm_period  (out_pwm_period),
    .out_pwm_compare (out_pwm_compare),
    .out_busy_res    (out_busy_res),
    .out_dropped     (out_dropped),
    .out_queued      (out_queued)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("queued_beep_sequencer regression: fail");
      $finish;
    end
  end

  // Check every result item taken from the block.
  always @(posedge clk) begin
    beep_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      got.tone_on = out_tone_on;
      got.period  = out_pwm_period;
      got.compare = out_pwm_compare;
      got.busy    = out_busy_res;
      got.dropped = out_dropped;
      got.queued  = out_queued;
      sb.check_result(got);
    end
  end

  // Receiver: random stall bursts, plus one long hold when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one item, waits until the block takes it, then predicts its result.
  task automatic send_item(input logic cmd, input logic [FREQ_W-1:0] f,
                           input logic [MS_W-1:0] t, input logic [MS_W-1:0] s);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_tone_freq  <= f;
    in_tone_ms    <= t;
    in_silence_ms <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(cmd, f, t, s);
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Writes one register; only called once every result has arrived. The enable
  // drops for one cycle so back-to-back writes never share a time step.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Mostly short durations so the queue keeps cycling; a few longer ones.
  function automatic logic [MS_W-1:0] rand_ms();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return MS_W'($urandom_range(0, 3));
    if (pick < 95) return MS_W'($urandom_range(4, 20));
    return MS_W'($urandom_range(21, 200));
  endfunction

  // Random ticks and requests; wide makes every duration full range.
  task automatic run_random(input int n, input int enq_pct, input bit wide);
    logic              cmd;
    logic [MS_W-1:0]   t;
    logic [MS_W-1:0]   s;
    repeat (n) begin
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_TICK;
      t   = wide ? MS_W'($urandom) : rand_ms();
      s   = wide ? MS_W'($urandom) : rand_ms();
      send_item(cmd, FREQ_W'($urandom), t, s);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Enqueue while disabled is dropped; a tick while idle changes nothing.
    send_item(CMD_ENQUEUE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();
    write_cfg(REG_ENABLED, 16'd1);
    write_cfg(REG_PERIOD_SCALE, 16'hFFFF);

    // Zero tone duration ends at the first tick.
    send_item(CMD_ENQUEUE, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);

    // Tone of two, mute of one, and a request arriving during the mute.
    send_item(CMD_ENQUEUE, 16'h0001, 16'h0002, 16'h0001);
    send_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_ENQUEUE, 16'h8000, 16'h0001, 16'h0000);
    send_item(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);

    // Fill the queue; the ninth request is dropped. Then play it all out.
    for (int i = 0; i < DEPTH + 1; i++) begin
      send_item(CMD_ENQUEUE, 16'hAAAA ^ i[15:0], 16'h0000, 16'h0000);
    end
    repeat (DEPTH) send_item(CMD_TICK, 16'h5555, 16'h0000, 16'h0000);
    wait_drained();

    // Unit scale, request-heavy traffic.
    write_cfg(REG_PERIOD_SCALE, 16'd1);
    run_random(300, 40, 1'b0);
    wait_drained();

    // Long receiver hold while the sender keeps offering items.
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    hold_request  = 1'b1;
    run_random(25, 50, 1'b0);
    wait_drained();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;

    // Zero scale: period and compare read zero even while a tone plays.
    write_cfg(REG_PERIOD_SCALE, 16'd0);
    run_random(200, 25, 1'b0);
    wait_drained();

    // Disabled: requests are dropped, playback still runs down.
    write_cfg(REG_ENABLED, 16'd0);
    write_cfg(REG_PERIOD_SCALE, 16'($urandom_range(2, 65534)));
    run_random(60, 50, 1'b1);
    wait_drained();

    // Full scale with frequent requests so the queue often overflows.
    write_cfg(REG_ENABLED, 16'd1);
    write_cfg(REG_PERIOD_SCALE, 16'hFFFF);
    run_random(300, 55, 1'b0);
    wait_drained();

    write_cfg(REG_PERIOD_SCALE, 16'($urandom_range(2, 65534)));
    run_random(250, 30, 1'b0);
    wait_drained();

    // Last stretch at full rate on both sides.
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    write_cfg(REG_PERIOD_SCALE, 16'd2);
    run_random(250, 40, 1'b0);
    wait_drained();

    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("queued_beep_sequencer regression: pass");
    end else begin
      $display("queued_beep_sequencer regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/qbs_pkg.sv
hw/rtl/qbs_store.sv
hw/rtl/queued_beep_sequencer.sv
sim/tb_queued_beep_sequencer.sv
